### rtl/core/signed_int_to_decimal_ascii_macros.svh
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_macros
// Assertion macros shared by the checker; clock i_clk and active-low reset
// i_rst_n are taken from the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// consequent checked in the same cycle
`define SITDA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("sitda assertion failed");

// consequent checked in the cycle after the antecedent
`define SITDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("sitda assertion failed");

`endif

### rtl/core/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types, constants and the double-dabble step for the signed integer
// to decimal ascii converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int ValueW      = 32;
    localparam int NumDigits   = 10;
    localparam int DigitW      = 4;
    localparam int BcdW        = NumDigits * DigitW;
    localparam int BitsPerCell = 4;
    localparam int NumCells    = ValueW / BitsPerCell;
    localparam int DigitIdxW   = $clog2(NumDigits);
    localparam int CharW       = 7;

    localparam logic [CharW-1:0] CharZero  = 7'd48;
    localparam logic [CharW-1:0] CharMinus = 7'd45;

    typedef logic [NumDigits-1:0][DigitW-1:0] t_bcd;

    // request travelling down the cell chain
    typedef struct packed {
        logic              neg;
        logic [ValueW-1:0] bin;
        t_bcd              bcd;
    } t_stage;

    // finished request handed to the serializer
    typedef struct packed {
        logic neg;
        t_bcd bcd;
    } t_result;

    // one shift-add-3 step: adjust every digit, then shift in the next bit
    function automatic t_bcd dabble_step(t_bcd bcd, logic bin_msb);
        t_bcd          adj;
        logic [BcdW:0] wide;
        adj = bcd;
        for (int k = 0; k < NumDigits; k++) begin
            if (adj[k] >= 4'd5) begin
                adj[k] = adj[k] + 4'd3;
            end
        end
        wide = {adj, bin_msb};
        return wide[BcdW-1:0];
    endfunction

endpackage

### rtl/core/sitda_cell.sv
// ----------------------------------------------------------------------------
// sitda_cell
// One cell of the conversion chain: consumes four magnitude bits with four
// double-dabble steps and hands the request to the next cell.
// ----------------------------------------------------------------------------
module sitda_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sitda_pkg::t_stage   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output sitda_pkg::t_stage   o_data
);

    logic              r_valid;
    sitda_pkg::t_stage r_data;
    sitda_pkg::t_stage n_data;
    logic              ready;

    // cell can take a request when empty or when its content moves on
    assign ready   = !r_valid || !i_stall;
    assign o_stall = !ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // four dabble steps on the incoming request
    always_comb begin
        sitda_pkg::t_bcd                 bcd;
        logic [sitda_pkg::ValueW-1:0]    bin;
        bcd = i_data.bcd;
        bin = i_data.bin;
        for (int s = 0; s < sitda_pkg::BitsPerCell; s++) begin
            bcd = sitda_pkg::dabble_step(bcd, bin[sitda_pkg::ValueW-1]);
            bin = {bin[sitda_pkg::ValueW-2:0], 1'b0};
        end
        n_data.neg = i_data.neg;
        n_data.bin = bin;
        n_data.bcd = bcd;
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

### rtl/core/sitda_ser.sv
// ----------------------------------------------------------------------------
// sitda_ser
// Serializer: turns one converted request into sign and digit characters,
// leading zeros dropped, with a registered output stage.
// ----------------------------------------------------------------------------
module sitda_ser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  sitda_pkg::t_result                i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sitda_pkg::CharW-1:0]       o_char_code,
    output logic                              o_last
);

    logic                              r_busy;
    logic                              r_neg;
    logic [sitda_pkg::DigitIdxW-1:0]   r_idx;
    sitda_pkg::t_bcd                   r_bcd;
    logic                              r_out_valid;
    logic [sitda_pkg::CharW-1:0]       r_char;
    logic                              r_last;

    logic                              out_free;
    logic                              adv;
    logic                              finishing;
    logic                              take;
    logic [sitda_pkg::DigitIdxW-1:0]   lead_idx;

    // handshake between held request and output register
    assign out_free  = !r_out_valid || !i_stall;
    assign adv       = r_busy && out_free;
    assign finishing = adv && !r_neg && (r_idx == '0);
    assign take      = i_valid && (!r_busy || finishing);
    assign o_stall   = r_busy && !finishing;

    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    // position of the most significant nonzero digit, zero gives digit 0
    always_comb begin
        lead_idx = '0;
        for (int k = 0; k < sitda_pkg::NumDigits; k++) begin
            if (i_data.bcd[k] != '0) begin
                lead_idx = sitda_pkg::DigitIdxW'(k);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
            end else if (finishing) begin
                r_busy <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_busy;
            end
        end
    end

    // held request: sign first, then digits from the top down
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_bcd <= i_data.bcd;
            r_neg <= i_data.neg;
            r_idx <= lead_idx;
        end else if (adv) begin
            if (r_neg) begin
                r_neg <= 1'b0;
            end else begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    // output character register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_neg) begin
                r_char <= sitda_pkg::CharMinus;
                r_last <= 1'b0;
            end else begin
                r_char <= sitda_pkg::CharZero + {3'b000, r_bcd[r_idx]};
                r_last <= (r_idx == '0);
            end
        end
    end

endmodule

### rtl/core/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a 32-bit signed integer into its decimal ascii text, one
// character per output request, most significant first.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | input     | i_valid / o_stall   | i_value [31:0] signed
//  out     | output    | o_valid / i_stall   | o_char_code [6:0], o_last
//
// A request passes through the eight dabble cell registers, then the
// serializer's held-request and output character registers.
// The serializer emits one character per cycle unless stalled, 1 to 11
// per request, and accepts the next request while emitting a last character.
// Stalls on the output hold the character register and back up the chain;
// up to ten requests can be in flight. Reset clears all valid state.
module signed_int_to_decimal_ascii (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [sitda_pkg::ValueW-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sitda_pkg::CharW-1:0]       o_char_code,
    output logic                              o_last
);

    logic [sitda_pkg::NumCells:0] chain_valid;
    logic [sitda_pkg::NumCells:0] chain_stall;
    sitda_pkg::t_stage            chain_data [sitda_pkg::NumCells+1];
    sitda_pkg::t_result           ser_data;

    // sign and magnitude into the first cell
    assign chain_data[0].neg = i_value[sitda_pkg::ValueW-1];
    assign chain_data[0].bin = i_value[sitda_pkg::ValueW-1] ?
                               (~i_value + 1'b1) : i_value;
    assign chain_data[0].bcd = '0;
    assign chain_valid[0]    = i_valid;
    assign o_stall           = chain_stall[0];

    // dabble cell chain
    for (genvar g = 0; g < sitda_pkg::NumCells; g++) begin : g_cell
        sitda_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .o_stall (chain_stall[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .i_stall (chain_stall[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    // finished digits to the serializer
    assign ser_data.neg = chain_data[sitda_pkg::NumCells].neg;
    assign ser_data.bcd = chain_data[sitda_pkg::NumCells].bcd;

    sitda_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (chain_valid[sitda_pkg::NumCells]),
        .o_stall     (chain_stall[sitda_pkg::NumCells]),
        .i_data      (ser_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

### rtl/core/sitda_checker.sv
// ----------------------------------------------------------------------------
// sitda_checker
// Port-level checks on the character stream of the converter.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_macros.svh"

module sitda_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [sitda_pkg::CharW-1:0]         o_char_code,
    input logic                                o_last
);

    logic is_minus;
    logic is_digit;

    assign is_minus  = (o_char_code == sitda_pkg::CharMinus);
    assign is_digit  = (o_char_code >= sitda_pkg::CharZero) &&
                       (o_char_code <= sitda_pkg::CharZero + 7'd9);

    // only a sign or a digit ever leaves
    `SITDA_ASSERT_SAME(a_char_legal, o_valid, is_minus || is_digit)

    // a sign never ends a number
    `SITDA_ASSERT_SAME(a_minus_not_last, o_valid && is_minus, !o_last)

    // a sign is followed at once by a nonzero leading digit
    `SITDA_ASSERT_NEXT(a_minus_then_digit, o_valid && !i_stall && is_minus,
                       o_valid && is_digit && (o_char_code != sitda_pkg::CharZero))

    // a stalled character holds
    `SITDA_ASSERT_NEXT(a_out_hold, o_valid && i_stall,
                       o_valid && $stable(o_char_code) && $stable(o_last))

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);

### tb/signed_int_to_decimal_ascii_test.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// Drives signed 32-bit integers into the decimal ascii converter and checks
// every character that comes out against a software conversion of the
// same value. Directed corner values come first, then random values of
// mixed digit counts and signs. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------

// one expected character of a number's text
typedef struct packed {
    logic [sitda_pkg::CharW-1:0] code;
    logic                        last;
} t_ascii_char;

// holds the text still owed for accepted requests and checks what arrives
class decimal_text_board;
    t_ascii_char pending_chars[$];
    int unsigned error_count;
    int unsigned char_count;
    int unsigned value_count;
    int unsigned negative_count;

    // expand an accepted value into its characters, most significant first
    function void note_value(logic signed [sitda_pkg::ValueW-1:0] value);
        logic [sitda_pkg::ValueW-1:0] magnitude;
        logic [3:0]                   digit_stack[sitda_pkg::NumDigits];
        int                           depth;
        t_ascii_char                  entry;
        depth = 0;
        magnitude = value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
        do begin
            digit_stack[depth] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
            depth++;
        end while (magnitude != 0);
        value_count++;
        if (value[31]) begin
            negative_count++;
            entry.code = sitda_pkg::CharMinus;
            entry.last = 1'b0;
            pending_chars.push_back(entry);
        end
        for (int k = depth - 1; k >= 0; k--) begin
            entry.code = sitda_pkg::CharZero + 7'(digit_stack[k]);
            entry.last = (k == 0);
            pending_chars.push_back(entry);
        end
    endfunction

    // compare one accepted character with the oldest one owed
    function void check_char(logic [sitda_pkg::CharW-1:0] code, logic last);
        t_ascii_char entry;
        if (pending_chars.size() == 0) begin
            $error("unexpected character: char_code %0d last %0b", code, last);
            error_count++;
            return;
        end
        entry = pending_chars.pop_front();
        char_count++;
        if (code !== entry.code) begin
            $error("char_code mismatch: expected %0d, actual %0d", entry.code, code);
            error_count++;
        end
        if (last !== entry.last) begin
            $error("last mismatch: expected %0b, actual %0b", entry.last, last);
            error_count++;
        end
    endfunction

    function int unsigned owed();
        return pending_chars.size();
    endfunction
endclass

module signed_int_to_decimal_ascii_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomValues = 125;
    localparam int WatchLimit   = 2000;
    localparam int DrainCycles  = 30;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_valid = 1'b0;
    logic                                 o_stall;
    logic signed [sitda_pkg::ValueW-1:0]  i_value = '0;
    logic                                 o_valid;
    logic                                 i_stall = 1'b0;
    logic [sitda_pkg::CharW-1:0]          o_char_code;
    logic                                 o_last;

    decimal_text_board board = new();
    int unsigned       idle_cycles = 0;
    int unsigned       stall_cycle = 0;
    int unsigned       stall_mode = 0;

    signed_int_to_decimal_ascii dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    // clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver stall: the style is redrawn at random from four styles as the run goes on
    always @(negedge i_clk) begin
        if (stall_cycle % 128 == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        stall_cycle <= stall_cycle + 1;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= ((stall_cycle % 7) < 3);
        endcase
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_char(o_char_code, o_last);
        end
    end

    // count cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    initial begin
        wait (idle_cycles >= WatchLimit);
        $display("timeout: no progress for %0d cycles, %0d characters owed",
                 WatchLimit, board.owed());
        $display("Simulation FAILED");
        $finish;
    end

    // present one request and hold it until accepted
    task automatic send_value(input logic signed [sitda_pkg::ValueW-1:0] value);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        board.note_value(value);
    endtask

    // drop valid for a number of cycles, with junk on the value lines
    task automatic pause_sender(input int unsigned cycles);
        @(negedge i_clk);
        i_valid <= 1'b0;
        i_value <= $urandom;
        repeat (cycles) @(negedge i_clk);
    endtask

    // random value of mixed shape: full width, small, near a power of ten,
    // or a random digit count
    function automatic logic signed [31:0] pick_value();
        int unsigned  digits;
        logic [31:0]  magnitude;
        logic [31:0]  powers[10];
        powers = '{32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
                   32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000};
        case ($urandom_range(0, 3))
            0: magnitude = $urandom;
            1: magnitude = $urandom_range(0, 99);
            2: magnitude = powers[$urandom_range(0, 9)] - $urandom_range(0, 1);
            default: begin
                digits = $urandom_range(1, 9);
                magnitude = $urandom_range(0, powers[digits] - 1);
            end
        endcase
        return $urandom_range(0, 1) ? -$signed(magnitude) : $signed(magnitude);
    endfunction

    // main sequence
    initial begin
        logic signed [31:0] corner_values[$];
        int unsigned        sent;
        int unsigned        burst;
        corner_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
                          999999999, -999999999, 1000000000, -1000000000,
                          1234567890, -1234567890, 2147483647, -2147483647,
                          32'sh80000000, 5, 42, -7, 1000001};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners back to back, then two of them again with gaps
        foreach (corner_values[n]) begin
            send_value(corner_values[n]);
        end
        pause_sender(5);
        send_value(32'sh80000000);
        pause_sender(3);
        send_value(0);

        // random values in bursts
        sent = 0;
        while (sent < RandomValues) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                send_value(pick_value());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 15));
            end
        end
        pause_sender(0);

        // drain and let stray characters show
        while (board.owed() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("converted %0d values (%0d negative) into %0d checked characters",
                 board.value_count, board.negative_count, board.char_count);
        if (board.error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
